### design/kruskal_union_find_masked_macros.svh
// Assertion helpers shared by the sequencer and the cost unit.
`ifndef KRUSKAL_UNION_FIND_MASKED_MACROS_SVH
`define KRUSKAL_UNION_FIND_MASKED_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define KUF_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define KUF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define KUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kuf_pkg.sv
`default_nettype none

package kuf_pkg;

    localparam int NODE_W   = 11;
    localparam int WEIGHT_W = 32;
    localparam int COST_W   = 48;
    localparam int BASE_W   = 11;
    localparam int MASK_W   = 16;
    localparam int MASK_IDX_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [BASE_W-1:0] BASE_COUNT_RESET = 11'd1024;
    localparam logic [MASK_W-1:0] EXTRA_MASK_RESET = 16'd0;

    // Item modes.
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_EDGE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_MASK = 1'b1;

    // Every memory entry carries a run tag; tag zero never matches the live one.
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 4'd0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'hF;

    typedef struct packed {
        logic                mode;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        logic                last_edge;
    } in_item_t;

    typedef struct packed {
        logic              joined;
        logic [COST_W-1:0] run_total;
        logic [COST_W-1:0] best_total;
    } out_item_t;

    // Hand-off from the sequencer to the cost unit.
    typedef struct packed {
        logic                fire;
        logic                start;
        logic                joined;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } cost_req_t;

endpackage

`default_nettype wire

### design/kruskal_union_find_masked.sv
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------
// item     | item_valid / item_ready   | item (kuf_pkg::in_item_t)
// result   | result_valid/result_ready | result (kuf_pkg::out_item_t)
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item is worked at a time. A begin or a skipped edge goes from accept straight to its result;
// a kept edge walks d_a + c_a + d_b + c_b links, where d counts the links walked up to the root
// and c the links repointed by compression (one memory read per cycle); a union adds 2 writes.
// A begin adds a sweep of all MAX_NODES+MAX_EXTRA entries when the run tag wraps (every 15th begin),
// and reset runs the same sweep before the first item is taken.
// A result waits in the output register while the next item works; config writes every cycle.
module kruskal_union_find_masked #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EXTRA = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output      logic                              item_ready,
    input  wire kuf_pkg::in_item_t                 item,
    output      logic                              result_valid,
    input  wire logic                              result_ready,
    output      kuf_pkg::out_item_t                result,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [kuf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kuf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_NODES + MAX_EXTRA;

    logic [kuf_pkg::BASE_W-1:0] base_count_reg, base_count_next;
    logic [kuf_pkg::MASK_W-1:0] extra_mask_reg, extra_mask_next;
    logic                       result_valid_reg, result_valid_next;
    kuf_pkg::out_item_t         result_reg, result_next;
    kuf_pkg::out_item_t         cost_result;
    kuf_pkg::cost_req_t         req;
    logic                       out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_count_next = base_count_reg;
        extra_mask_next = extra_mask_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                kuf_pkg::REG_BASE_COUNT: base_count_next = cfg_data[kuf_pkg::BASE_W-1:0];
                kuf_pkg::REG_EXTRA_MASK: extra_mask_next = cfg_data[kuf_pkg::MASK_W-1:0];
                default:                 base_count_next = base_count_reg;
            endcase
        end
    end

    assign out_free = !result_valid_reg || result_ready;

    kuf_seq #(
        .DEPTH     (DEPTH),
        .MAX_EXTRA (MAX_EXTRA)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .base_count (base_count_reg),
        .extra_mask (extra_mask_reg),
        .out_free   (out_free),
        .req        (req)
    );

    kuf_cost u_cost (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .result_next (cost_result)
    );

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (req.fire)
        begin
            result_next       = cost_result;
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_count_reg   <= kuf_pkg::BASE_COUNT_RESET;
            extra_mask_reg   <= kuf_pkg::EXTRA_MASK_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            base_count_reg   <= base_count_next;
            extra_mask_reg   <= extra_mask_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### design/kuf_ram.sv
`default_nettype none

module kuf_ram #(
    parameter int DEPTH  = 2,
    parameter int DATA_W = 1
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    // A read of the entry being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rd_data_reg <= wdata;
        end
        else
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

### design/kuf_cost.sv
`default_nettype none

module kuf_cost (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kuf_pkg::cost_req_t req,
    output      kuf_pkg::out_item_t result_next
);

`include "kruskal_union_find_masked_macros.svh"

    logic [kuf_pkg::COST_W-1:0] run_cost_reg;
    logic [kuf_pkg::COST_W-1:0] run_cost_next;
    logic [kuf_pkg::COST_W-1:0] best_cost_reg;
    logic [kuf_pkg::COST_W-1:0] best_cost_next;
    logic [kuf_pkg::COST_W-1:0] run_new;
    logic [kuf_pkg::COST_W-1:0] best_new;
    logic [kuf_pkg::COST_W:0]   run_sum;

    assign run_sum = {1'b0, run_cost_reg} + (kuf_pkg::COST_W + 1)'(req.weight);

    always_comb
    begin
        if (req.start)
        begin
            run_new  = kuf_pkg::COST_W'(req.weight);
            best_new = best_cost_reg;
        end
        else
        begin
            if (req.joined)
            begin
                run_new = run_sum[kuf_pkg::COST_W] ? kuf_pkg::COST_MAX
                                                   : run_sum[kuf_pkg::COST_W-1:0];
            end
            else
            begin
                run_new = run_cost_reg;
            end
            best_new = (req.last && (run_new < best_cost_reg)) ? run_new : best_cost_reg;
        end
    end

    assign run_cost_next  = req.fire ? run_new : run_cost_reg;
    assign best_cost_next = req.fire ? best_new : best_cost_reg;

    assign result_next.joined     = req.joined && !req.start;
    assign result_next.run_total  = run_new;
    assign result_next.best_total = best_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cost_reg  <= '0;
            best_cost_reg <= kuf_pkg::COST_MAX;
        end
        else
        begin
            run_cost_reg  <= run_cost_next;
            best_cost_reg <= best_cost_next;
        end
    end

    `KUF_ASSERT_NEXT(a_best_never_rises, clk, rst_n, 1'b1, best_cost_reg <= $past(best_cost_reg), "best total rose")
    `KUF_ASSERT_IMPL(a_join_never_lowers, clk, rst_n, req.fire && req.joined && !req.start, run_new >= run_cost_reg, "joined edge lowered the run total")

endmodule

`default_nettype wire

### design/kuf_seq.sv
`default_nettype none

module kuf_seq #(
    parameter int DEPTH     = 1040,
    parameter int MAX_EXTRA = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output      logic                          item_ready,
    input  wire kuf_pkg::in_item_t             item,
    input  wire logic [kuf_pkg::BASE_W-1:0]    base_count,
    input  wire logic [kuf_pkg::MASK_W-1:0]    extra_mask,
    input  wire logic                          out_free,
    output      kuf_pkg::cost_req_t            req
);

`include "kruskal_union_find_masked_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SZ_W  = $clog2(DEPTH + 1);
    localparam int ENT_W = kuf_pkg::EPOCH_W + IDX_W + SZ_W;
    localparam int CMP_W = (IDX_W + 1 > kuf_pkg::NODE_W) ? IDX_W + 1 : kuf_pkg::NODE_W;

    localparam logic [2:0] ST_SWEEP   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_FIND    = 3'd2;
    localparam logic [2:0] ST_PRESS   = 3'd3;
    localparam logic [2:0] ST_UNION_A = 3'd4;
    localparam logic [2:0] ST_UNION_B = 3'd5;
    localparam logic [2:0] ST_RESULT  = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [IDX_W-1:0]               sweep_reg, sweep_next;
    logic                           sweep_item_reg, sweep_item_next;
    logic [kuf_pkg::EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic                           phase_reg, phase_next;
    logic [IDX_W-1:0]               cur_reg, cur_next;
    logic [IDX_W-1:0]               node_a_reg, node_a_next;
    logic [IDX_W-1:0]               node_b_reg, node_b_next;
    logic [IDX_W-1:0]               root_x_reg, root_x_next;
    logic [IDX_W-1:0]               root_y_reg, root_y_next;
    logic [SZ_W-1:0]                size_x_reg, size_x_next;
    logic [SZ_W-1:0]                size_y_reg, size_y_next;
    logic                           start_reg, start_next;
    logic                           joined_reg, joined_next;
    logic                           last_reg, last_next;
    logic [kuf_pkg::WEIGHT_W-1:0]   weight_reg, weight_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    logic                 rd_live;
    logic [IDX_W-1:0]     v_parent;
    logic [SZ_W-1:0]      v_size;
    logic [IDX_W-1:0]     cur_root;

    logic [CMP_W-1:0]           a_ext;
    logic [CMP_W-1:0]           b_ext;
    logic                       a_ok;
    logic                       b_ok;
    logic                       a_extra;
    logic [kuf_pkg::NODE_W-1:0] extra_off;
    logic                       extra_ok;
    logic                       take;
    logic [IDX_W-1:0]           a_idx;
    logic [IDX_W-1:0]           b_idx;

    kuf_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry written in an earlier run reads as a singleton set.
    assign rd_live  = (ram_rdata[ENT_W-1 -: kuf_pkg::EPOCH_W] == epoch_reg);
    assign v_parent = rd_live ? ram_rdata[SZ_W +: IDX_W] : cur_reg;
    assign v_size   = rd_live ? ram_rdata[SZ_W-1:0] : SZ_W'(1);
    assign cur_root = phase_reg ? root_y_reg : root_x_reg;

    assign a_ext = CMP_W'(item.node_a);
    assign b_ext = CMP_W'(item.node_b);
    assign a_ok  = (a_ext != '0) && (a_ext <= CMP_W'(DEPTH));
    assign b_ok  = (b_ext != '0) && (b_ext <= CMP_W'(DEPTH));
    assign a_idx = IDX_W'(a_ext - CMP_W'(1));
    assign b_idx = IDX_W'(b_ext - CMP_W'(1));

    assign a_extra   = (item.node_a > base_count);
    assign extra_off = item.node_a - base_count - kuf_pkg::NODE_W'(1);
    assign extra_ok  = (extra_off < kuf_pkg::NODE_W'(MAX_EXTRA))
                    && (extra_off < kuf_pkg::NODE_W'(kuf_pkg::MASK_W))
                    && extra_mask[extra_off[kuf_pkg::MASK_IDX_W-1:0]];
    assign take      = a_ok && b_ok && (!a_extra || extra_ok);

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        sweep_item_next = sweep_item_reg;
        epoch_next      = epoch_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        node_a_next     = node_a_reg;
        node_b_next     = node_b_reg;
        root_x_next     = root_x_reg;
        root_y_next     = root_y_reg;
        size_x_next     = size_x_reg;
        size_y_next     = size_y_reg;
        start_next      = start_reg;
        joined_next     = joined_reg;
        last_next       = last_reg;
        weight_next     = weight_reg;

        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = '0;
        ram_raddr = cur_reg;

        item_ready = 1'b0;
        req.fire   = 1'b0;
        req.start  = start_reg;
        req.joined = joined_reg;
        req.last   = last_reg;
        req.weight = weight_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = {kuf_pkg::EPOCH_NONE, {(IDX_W + SZ_W){1'b0}}};
                if (sweep_reg == IDX_W'(DEPTH - 1))
                begin
                    sweep_next      = '0;
                    sweep_item_next = 1'b0;
                    state_next      = sweep_item_reg ? ST_RESULT : ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    start_next  = (item.mode == kuf_pkg::MODE_BEGIN);
                    joined_next = 1'b0;
                    last_next   = item.last_edge;
                    weight_next = item.weight;
                    node_a_next = a_idx;
                    node_b_next = b_idx;
                    phase_next  = 1'b0;
                    if (item.mode == kuf_pkg::MODE_BEGIN)
                    begin
                        // A new run tag empties the forest; tags are swept when they wrap.
                        if (epoch_reg == kuf_pkg::EPOCH_LAST)
                        begin
                            epoch_next      = kuf_pkg::EPOCH_FIRST;
                            sweep_item_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + kuf_pkg::EPOCH_FIRST;
                            state_next = ST_RESULT;
                        end
                    end
                    else if (take)
                    begin
                        ram_raddr  = a_idx;
                        cur_next   = a_idx;
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_FIND:
            begin
                if (v_parent == cur_reg)
                begin
                    if (phase_reg)
                    begin
                        root_y_next = cur_reg;
                        size_y_next = v_size;
                        ram_raddr   = node_b_reg;
                        cur_next    = node_b_reg;
                    end
                    else
                    begin
                        root_x_next = cur_reg;
                        size_x_next = v_size;
                        ram_raddr   = node_a_reg;
                        cur_next    = node_a_reg;
                    end
                    state_next = ST_PRESS;
                end
                else
                begin
                    ram_raddr = v_parent;
                    cur_next  = v_parent;
                end
            end

            ST_PRESS:
            begin
                if (v_parent == cur_root)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        ram_raddr  = node_b_reg;
                        cur_next   = node_b_reg;
                        state_next = ST_FIND;
                    end
                    else if (root_x_reg == root_y_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_UNION_A;
                    end
                end
                else
                begin
                    // Point this node of the walk straight at the root.
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg;
                    ram_wdata  = {epoch_reg, cur_root, v_size};
                    ram_raddr  = v_parent;
                    cur_next   = v_parent;
                end
            end

            ST_UNION_A:
            begin
                ram_we = 1'b1;
                if (size_x_reg < size_y_reg)
                begin
                    ram_waddr = root_x_reg;
                    ram_wdata = {epoch_reg, root_y_reg, size_x_reg};
                end
                else
                begin
                    ram_waddr = root_y_reg;
                    ram_wdata = {epoch_reg, root_x_reg, size_y_reg};
                end
                state_next = ST_UNION_B;
            end

            ST_UNION_B:
            begin
                ram_we = 1'b1;
                if (size_x_reg < size_y_reg)
                begin
                    ram_waddr = root_y_reg;
                    ram_wdata = {epoch_reg, root_y_reg, size_x_reg + size_y_reg};
                end
                else
                begin
                    ram_waddr = root_x_reg;
                    ram_wdata = {epoch_reg, root_x_reg, size_x_reg + size_y_reg};
                end
                joined_next = 1'b1;
                state_next  = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    req.fire   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            sweep_item_reg <= 1'b0;
            epoch_reg      <= kuf_pkg::EPOCH_FIRST;
            phase_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            sweep_item_reg <= sweep_item_next;
            epoch_reg      <= epoch_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        node_a_reg <= node_a_next;
        node_b_reg <= node_b_next;
        root_x_reg <= root_x_next;
        root_y_reg <= root_y_next;
        size_x_reg <= size_x_next;
        size_y_reg <= size_y_next;
        start_reg  <= start_next;
        joined_reg <= joined_next;
        last_reg   <= last_next;
        weight_reg <= weight_next;
    end

    `KUF_ASSERT_HOLDS(a_epoch_live, clk, rst_n, epoch_reg != kuf_pkg::EPOCH_NONE, "live run tag is the empty tag")
    `KUF_ASSERT_IMPL(a_union_distinct, clk, rst_n, state_reg == ST_UNION_A, root_x_reg != root_y_reg, "union of a set with itself")
    `KUF_ASSERT_IMPL(a_join_after_union, clk, rst_n, req.fire && req.joined, $past(state_reg) == ST_UNION_B || $past(state_reg) == ST_RESULT, "joined result without a union")

endmodule

`default_nettype wire

### verif/kruskal_union_find_masked_test.sv
module kruskal_union_find_masked_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_LIMIT  = 1040;
    localparam int EXTRA_SLOTS = 16;
    localparam int RANDOM_ITEMS = 2000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    kuf_pkg::in_item_t              item = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    kuf_pkg::out_item_t             result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [kuf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kuf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    kruskal_union_find_masked i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Our own copy of the union-find forest, costs and registers.
    int unsigned                link_of [NODE_LIMIT];
    int unsigned                tree_size [NODE_LIMIT];
    logic [kuf_pkg::COST_W-1:0] run_acc;
    logic [kuf_pkg::COST_W-1:0] best_acc;
    logic [kuf_pkg::BASE_W-1:0] base_cnt;
    logic [kuf_pkg::MASK_W-1:0] ext_mask;

    kuf_pkg::out_item_t forest_outcomes[$];

    int  fail_count = 0;
    int  results_seen = 0;
    int  joins_seen = 0;
    int  begins_sent = 0;
    int  edges_sent = 0;
    int  cfg_writes = 0;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;
    int  hold_cycles = 0;
    int  ready_stall = 0;

    function automatic void clear_forest_model();
        for (int i = 0; i < NODE_LIMIT; i++)
        begin
            link_of[i] = i;
            tree_size[i] = 1;
        end
    endfunction

    function automatic int unsigned root_of(int unsigned n);
        int unsigned top;
        int unsigned walk;
        int unsigned nxt;
        top = n;
        while (link_of[top] != top)
            top = link_of[top];
        walk = n;
        while (link_of[walk] != top)
        begin
            nxt = link_of[walk];
            link_of[walk] = top;
            walk = nxt;
        end
        return top;
    endfunction

    function automatic kuf_pkg::out_item_t kruskal_step(kuf_pkg::in_item_t it);
        kuf_pkg::out_item_t       r;
        int unsigned              a;
        int unsigned              b;
        int unsigned              base;
        int unsigned              off;
        int unsigned              ra;
        int unsigned              rb;
        bit                       take;
        logic [kuf_pkg::COST_W:0] sum;
        r = '0;
        a = 32'(it.node_a);
        b = 32'(it.node_b);
        base = 32'(base_cnt);
        if (it.mode == kuf_pkg::MODE_BEGIN)
        begin
            clear_forest_model();
            run_acc = kuf_pkg::COST_W'(it.weight);
        end
        else
        begin
            take = 1'b1;
            if (a == 0 || a > NODE_LIMIT || b == 0 || b > NODE_LIMIT)
                take = 1'b0;
            if (take && a > base)
            begin
                off = a - base - 1;
                if (off >= EXTRA_SLOTS)
                    take = 1'b0;
                else if (!ext_mask[off[kuf_pkg::MASK_IDX_W-1:0]])
                    take = 1'b0;
            end
            if (take)
            begin
                ra = root_of(a - 1);
                rb = root_of(b - 1);
                if (ra != rb)
                begin
                    if (tree_size[ra] < tree_size[rb])
                    begin
                        tree_size[rb] += tree_size[ra];
                        link_of[ra] = rb;
                    end
                    else
                    begin
                        tree_size[ra] += tree_size[rb];
                        link_of[rb] = ra;
                    end
                    sum = {1'b0, run_acc} + (kuf_pkg::COST_W + 1)'(it.weight);
                    run_acc = sum[kuf_pkg::COST_W] ? kuf_pkg::COST_MAX
                                                   : sum[kuf_pkg::COST_W-1:0];
                    r.joined = 1'b1;
                end
            end
            if (it.last_edge && run_acc < best_acc)
                best_acc = run_acc;
        end
        r.run_total = run_acc;
        r.best_total = best_acc;
        return r;
    endfunction

    function automatic void check_field(string label, logic [kuf_pkg::COST_W-1:0] want,
                                        logic [kuf_pkg::COST_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        kuf_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (forest_outcomes.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, result);
            end
            else
            begin
                want = forest_outcomes.pop_front();
                if (result.joined === 1'b1)
                    joins_seen++;
                check_field("joined", kuf_pkg::COST_W'(want.joined),
                            kuf_pkg::COST_W'(result.joined));
                check_field("run_total", want.run_total, result.run_total);
                check_field("best_total", want.best_total, result.best_total);
            end
        end
    end

    // Mostly no gap, some short ones and a rare long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles--;
            end
            else if (ready_stall > 0)
            begin
                result_ready <= 1'b0;
                ready_stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!receiver_steady && $urandom_range(0, 99) < 20)
                    ready_stall = 1 + pick_gap();
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for a following beat.
    task automatic send_item(kuf_pkg::in_item_t it);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        forest_outcomes.push_back(kruskal_step(it));
        if (it.mode == kuf_pkg::MODE_BEGIN)
            begins_sent++;
        else
            edges_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (forest_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [kuf_pkg::CFG_IDX_W-1:0] idx,
                             logic [kuf_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == kuf_pkg::REG_BASE_COUNT)
            base_cnt = data[kuf_pkg::BASE_W-1:0];
        else
            ext_mask = data[kuf_pkg::MASK_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // The upper data bits above the base count field are don't-care noise.
    task automatic set_config(int unsigned base, logic [kuf_pkg::MASK_W-1:0] mask);
        drain_results();
        write_reg(kuf_pkg::REG_BASE_COUNT, {5'($urandom), base[kuf_pkg::BASE_W-1:0]});
        write_reg(kuf_pkg::REG_EXTRA_MASK, mask);
    endtask

    function automatic kuf_pkg::in_item_t edge_of(int unsigned a, int unsigned b,
                                                  logic [kuf_pkg::WEIGHT_W-1:0] w, bit last);
        kuf_pkg::in_item_t it;
        it.mode = kuf_pkg::MODE_EDGE;
        it.node_a = a[kuf_pkg::NODE_W-1:0];
        it.node_b = b[kuf_pkg::NODE_W-1:0];
        it.weight = w;
        it.last_edge = last;
        return it;
    endfunction

    // Node fields and the last flag mean nothing on a begin beat, so they are random.
    function automatic kuf_pkg::in_item_t begin_of(logic [kuf_pkg::WEIGHT_W-1:0] w);
        kuf_pkg::in_item_t it;
        it.mode = kuf_pkg::MODE_BEGIN;
        it.node_a = kuf_pkg::NODE_W'($urandom_range(0, 2047));
        it.node_b = kuf_pkg::NODE_W'($urandom_range(0, 2047));
        it.weight = w;
        it.last_edge = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic test_reset_forest();
        send_item(edge_of(1, 2, 32'd7, 1'b0));
        send_item(edge_of(2, 1, 32'd5, 1'b0));
        send_item(edge_of(3, 3, 32'd9, 1'b1));
    endtask

    task automatic test_node_bounds();
        send_item(begin_of(32'hFFFF_FFFF));
        send_item(edge_of(0, 5, 32'd1, 1'b0));
        send_item(edge_of(5, 0, 32'd1, 1'b0));
        send_item(edge_of(1041, 2, 32'd1, 1'b0));
        send_item(edge_of(2, 2047, 32'd1, 1'b0));
        send_item(edge_of(1024, 1, 32'hFFFF_FFFF, 1'b0));
        send_item(edge_of(1040, 1, 32'd3, 1'b0));
        // The second end is never masked, so this one joins.
        send_item(edge_of(1, 1040, 32'd3, 1'b0));
        send_item(edge_of(0, 1, 32'd3, 1'b1));
    endtask

    task automatic test_extra_mask();
        set_config(1024, 16'h8001);
        send_item(begin_of(32'd0));
        send_item(edge_of(1025, 1, 32'd4, 1'b0));
        send_item(edge_of(1040, 2, 32'd4, 1'b0));
        send_item(edge_of(1026, 3, 32'd4, 1'b0));
        send_item(edge_of(1, 2, 32'd0, 1'b1));
        set_config(0, 16'hFFFF);
        send_item(begin_of(32'd3));
        send_item(edge_of(16, 1, 32'd2, 1'b0));
        send_item(edge_of(17, 1, 32'd2, 1'b1));
        set_config(2047, 16'h0000);
        send_item(begin_of(32'd1));
        send_item(edge_of(1040, 1, 32'd6, 1'b1));
        set_config(1, 16'h0002);
        send_item(begin_of(32'd0));
        send_item(edge_of(2, 1, 32'd8, 1'b0));
        send_item(edge_of(3, 1, 32'd8, 1'b1));
    endtask

    task automatic test_run_chaining();
        set_config(1024, 16'h0000);
        send_item(begin_of(32'd100));
        send_item(edge_of(1, 2, 32'd50, 1'b1));
        // No new begin: the total keeps growing, and a worse finish keeps the best.
        send_item(edge_of(3, 4, 32'd10, 1'b0));
        send_item(edge_of(2, 1, 32'd10, 1'b1));
        send_item(begin_of(32'd0));
        send_item(edge_of(5, 6, 32'd1, 1'b1));
    endtask

    function automatic logic [kuf_pkg::WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 60)
            return $urandom_range(0, 255);
        return $urandom;
    endfunction

    function automatic int unsigned pick_node(int unsigned lo, int unsigned span);
        int r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 60)
            return lo + $urandom_range(0, span - 1);
        if (r < 80)
        begin
            n = 32'(base_cnt) + 1 + $urandom_range(0, EXTRA_SLOTS + 1);
            return (n > 2047) ? 2047 : n;
        end
        if (r < 95)
            return $urandom_range(1, NODE_LIMIT);
        return $urandom_range(0, 2047);
    endfunction

    // One run: usually a begin, then edges whose ends mostly lie in a window of nodes so that
    // sets grow, merge and get compressed; now and then a raw noise beat.
    task automatic random_run();
        int                len;
        int unsigned       span;
        int unsigned       lo;
        bit                last;
        kuf_pkg::in_item_t noise;
        len = $urandom_range(3, 60);
        case ($urandom_range(0, 3))
            0: span = 4;
            1: span = 16;
            2: span = 64;
            default: span = 400;
        endcase
        lo = $urandom_range(1, NODE_LIMIT - span + 1);
        if ($urandom_range(0, 9) != 0)
            send_item(begin_of(($urandom_range(0, 1) == 1) ? $urandom_range(0, 1000)
                                                              : $urandom));
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                noise.mode = 1'($urandom_range(0, 1));
                noise.node_a = kuf_pkg::NODE_W'($urandom_range(0, 2047));
                noise.node_b = kuf_pkg::NODE_W'($urandom_range(0, 2047));
                noise.weight = $urandom;
                noise.last_edge = 1'($urandom_range(0, 1));
                send_item(noise);
            end
            else
            begin
                if (k == len - 1)
                    last = ($urandom_range(0, 9) != 0);
                else
                    last = ($urandom_range(0, 29) == 0);
                send_item(edge_of(pick_node(lo, span), pick_node(lo, span),
                                  pick_weight(), last));
            end
        end
    endtask

    task automatic test_random_runs();
        int unsigned bases [8];
        int unsigned masks [8];
        int          budget;
        int          start;
        bases = '{1024, 1024, 1000, 1, 0, 2047, 1030, 512};
        masks = '{0, 32'hFFFF, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  32'hFFFF, $urandom_range(0, 65535), $urandom_range(0, 65535), 32'h00FF};
        budget = RANDOM_ITEMS / 8;
        for (int p = 0; p < 8; p++)
        begin
            set_config(bases[p], masks[p][kuf_pkg::MASK_W-1:0]);
            // One phase runs with no idling on either side.
            sender_steady = (p == 3);
            receiver_steady = (p == 3);
            start = begins_sent + edges_sent;
            while (begins_sent + edges_sent - start < budget)
                random_run();
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        set_config(1024, 16'hFFFF);
        send_item(begin_of(32'd12));
        hold_cycles = 400;
        sender_steady = 1'b1;
        for (int k = 0; k < 24; k++)
            send_item(edge_of($urandom_range(1, 40), $urandom_range(1, 40),
                              pick_weight(), k == 23));
        sender_steady = 1'b0;
        // Then the sender sits idle until every result has come back.
        drain_results();
        repeat ($urandom_range(5, 30)) @(negedge clk);
        send_item(edge_of(1, 1040, 32'd9, 1'b1));
    endtask

    initial
    begin
        clear_forest_model();
        run_acc = '0;
        best_acc = kuf_pkg::COST_MAX;
        base_cnt = kuf_pkg::BASE_COUNT_RESET;
        ext_mask = kuf_pkg::EXTRA_MASK_RESET;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_forest();
        test_node_bounds();
        test_extra_mask();
        test_run_chaining();
        test_random_runs();
        test_backpressure();

        drain_results();
        repeat (60) @(negedge clk);
        $display("Run covered %0d begin beats and %0d edge beats over %0d register writes,",
                 begins_sent, edges_sent, cfg_writes);
        $display("with %0d results checked, %0d of them joins, and %0d failures.",
                 results_seen, joins_seen, fail_count);
        if (fail_count == 0)
            $display("kruskal_union_find_masked: match");
        else
            $display("kruskal_union_find_masked: mismatch");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("Timeout with %0d results still outstanding.", forest_outcomes.size());
        $display("kruskal_union_find_masked: mismatch");
        $finish;
    end

endmodule
